>>> rtl/blsr_pkg.sv
// Shared types and constants for the bounded sequential record list.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package blsr_pkg;

  localparam int BLSR_CAPACITY = 32;

  typedef enum logic [2:0] {
    CMD_INS_END    = 3'd0,
    CMD_INS_FRONT  = 3'd1,
    CMD_INS_SORTED = 3'd2,
    CMD_DEL_KEY    = 3'd3,
    CMD_DEL_FIRST  = 3'd4,
    CMD_DEL_LAST   = 3'd5,
    CMD_READ_POS   = 3'd6,
    CMD_FIND_KEY   = 3'd7
  } blsr_op_e;

  typedef struct packed {
    blsr_op_e           cmd;
    logic signed [31:0] entry_key;
    logic [63:0]        entry_payload;
    logic [5:0]         position;
  } blsr_in_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] found_key;
    logic [63:0]        found_payload;
    logic [5:0]         count;
    logic               is_full;
    logic               is_empty;
  } blsr_out_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        payload;
  } blsr_rec_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic idx_zero;
    logic scan_step;
    logic scan_ge;
    logic shift_init;
    logic dir_down;
    logic shift_step;
    logic write_new;
    logic cnt_inc;
    logic cnt_dec;
    logic rd_pos;
    logic cap_found;
    logic set_ok;
    logic res_load;
  } blsr_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic miss;
    logic busy;
    logic full;
    logic empty;
    logic pos_ok;
    logic out_free;
  } blsr_sts_t;

endpackage

>>> rtl/blsr_datapath.sv
// Datapath: record memory, entry count, scan and shift pointers, result register.
// Driven by blsr_ctrl through blsr_ctl_t; depends on blsr_pkg.
`timescale 1ns / 1ps

module blsr_datapath
  import blsr_pkg::*;
#(
  parameter int CAPACITY = BLSR_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  blsr_in_t  in_data_i,
  input  blsr_ctl_t ctl_i,
  output blsr_sts_t sts_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output blsr_out_t out_data_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 6) ? CW : 6;

  blsr_rec_t mem [CAPACITY];
  blsr_rec_t rdata_q;

  logic signed [31:0] key_q;
  logic [63:0]        payload_q;
  logic [5:0]         pos_q;
  logic [CW-1:0]      cnt_q, idx_q, scan_q, rp_q, n_q;
  logic [AW-1:0]      pa_q;
  logic               pend_q, dir_q, ok_q, ov_q;
  blsr_rec_t          found_q;
  blsr_out_t          out_q;

  logic               re, we, hit, miss;
  logic [AW-1:0]      ra, wa;
  blsr_rec_t          wd;
  logic [PW-1:0]      pos_w, cnt_w;

  assign pos_w = PW'(pos_q);
  assign cnt_w = PW'(cnt_q);

  assign hit  = pend_q && (ctl_i.scan_ge ? (rdata_q.key >= key_q) : (rdata_q.key == key_q));
  assign miss = !hit && (scan_q == cnt_q);

  assign sts_o.hit      = hit;
  assign sts_o.miss     = miss;
  assign sts_o.busy     = (n_q != '0) || pend_q;
  assign sts_o.full     = (cnt_q == CW'(CAPACITY));
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.pos_ok   = (pos_w != '0) && (pos_w <= cnt_w);
  assign sts_o.out_free = !ov_q || out_ready_i;

  always_comb begin
    re = 1'b0;
    ra = '0;
    we = 1'b0;
    wa = '0;
    wd = rdata_q;
    if (ctl_i.scan_step && !hit && !miss) begin
      re = 1'b1;
      ra = AW'(scan_q);
    end
    if (ctl_i.shift_step) begin
      if (pend_q) begin
        we = 1'b1;
        wa = dir_q ? (pa_q - AW'(1)) : (pa_q + AW'(1));
      end
      if (n_q != '0) begin
        re = 1'b1;
        ra = AW'(rp_q);
      end
    end
    if (ctl_i.rd_pos) begin
      re = 1'b1;
      ra = AW'(pos_w - PW'(1));
    end
    if (ctl_i.write_new) begin
      we      = 1'b1;
      wa      = AW'(idx_q);
      wd.key  = key_q;
      wd.payload = payload_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
      n_q    <= '0;
    end else begin
      if (ctl_i.load) begin
        pend_q <= 1'b0;
      end
      if (ctl_i.scan_step) begin
        if (hit || miss) begin
          pend_q <= 1'b0;
        end else begin
          pend_q <= 1'b1;
        end
      end
      if (ctl_i.shift_init) begin
        pend_q <= 1'b0;
        n_q    <= ctl_i.dir_down ? (cnt_q - idx_q - CW'(1)) : (cnt_q - idx_q);
      end
      if (ctl_i.shift_step) begin
        if (n_q != '0) begin
          n_q    <= n_q - CW'(1);
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
      end
      if (ctl_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (ctl_i.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (ctl_i.res_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q     <= in_data_i.entry_key;
      payload_q <= in_data_i.entry_payload;
      pos_q     <= in_data_i.position;
      idx_q     <= ctl_i.idx_zero ? '0 : cnt_q;
      scan_q    <= '0;
      ok_q      <= 1'b0;
      found_q   <= '0;
    end
    if (ctl_i.scan_step) begin
      if (hit) begin
        idx_q <= CW'(pa_q);
      end else if (miss) begin
        idx_q <= cnt_q;
      end else begin
        scan_q <= scan_q + CW'(1);
        pa_q   <= AW'(scan_q);
      end
    end
    if (ctl_i.shift_init) begin
      dir_q <= ctl_i.dir_down;
      rp_q  <= ctl_i.dir_down ? (idx_q + CW'(1)) : (cnt_q - CW'(1));
    end
    if (ctl_i.shift_step && (n_q != '0)) begin
      pa_q <= AW'(rp_q);
      rp_q <= dir_q ? (rp_q + CW'(1)) : (rp_q - CW'(1));
    end
    if (ctl_i.set_ok) begin
      ok_q <= 1'b1;
    end
    if (ctl_i.cap_found) begin
      found_q <= rdata_q;
    end
    if (ctl_i.res_load) begin
      out_q.ok            <= ok_q;
      out_q.found_key     <= found_q.key;
      out_q.found_payload <= found_q.payload;
      out_q.count         <= 6'(cnt_q);
      out_q.is_full       <= (cnt_q == CW'(CAPACITY));
      out_q.is_empty      <= (cnt_q == '0);
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re && (wa == ra)))
    else $error("memory read and write at the same slot");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_res_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.res_load |-> (!ov_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.cnt_inc && !ctl_i.cnt_dec) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("entry count did not advance by one");

endmodule

>>> rtl/blsr_ctrl.sv
// Controller state machine: decodes the command and sequences scan, shift, read and result steps.
// Drives blsr_datapath through blsr_ctl_t; depends on blsr_pkg.
`timescale 1ns / 1ps

module blsr_ctrl
  import blsr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  blsr_op_e  cmd_i,
  input  blsr_sts_t sts_i,
  output blsr_ctl_t ctl_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHINIT = 3'd3;
  localparam logic [2:0] S_SHUP   = 3'd4;
  localparam logic [2:0] S_SHDN   = 3'd5;
  localparam logic [2:0] S_RDW    = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  logic [2:0] state_q, state_d;
  blsr_op_e   cmd_q, cmd_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    ctl_o         = '0;
    ctl_o.scan_ge = (cmd_q == CMD_INS_SORTED);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load     = 1'b1;
          ctl_o.idx_zero = (cmd_i == CMD_INS_FRONT) || (cmd_i == CMD_DEL_FIRST);
          cmd_d          = cmd_i;
          state_d        = S_DISP;
        end
      end
      S_DISP: begin
        unique case (cmd_q)
          CMD_INS_END, CMD_INS_FRONT: begin
            if (sts_i.full) begin
              state_d = S_RESP;
            end else begin
              ctl_o.shift_init = 1'b1;
              state_d          = S_SHUP;
            end
          end
          CMD_INS_SORTED: state_d = sts_i.full ? S_RESP : S_SCAN;
          CMD_DEL_KEY, CMD_FIND_KEY: state_d = S_SCAN;
          CMD_DEL_FIRST: begin
            if (sts_i.empty) begin
              state_d = S_RESP;
            end else begin
              ctl_o.shift_init = 1'b1;
              ctl_o.dir_down   = 1'b1;
              state_d          = S_SHDN;
            end
          end
          CMD_DEL_LAST: begin
            if (!sts_i.empty) begin
              ctl_o.cnt_dec = 1'b1;
              ctl_o.set_ok  = 1'b1;
            end
            state_d = S_RESP;
          end
          CMD_READ_POS: begin
            if (sts_i.pos_ok) begin
              ctl_o.rd_pos = 1'b1;
              state_d      = S_RDW;
            end else begin
              state_d = S_RESP;
            end
          end
          default: state_d = S_RESP;
        endcase
      end
      S_SCAN: begin
        ctl_o.scan_step = 1'b1;
        if (sts_i.hit || sts_i.miss) begin
          if (cmd_q == CMD_INS_SORTED) begin
            state_d = S_SHINIT;
          end else if (cmd_q == CMD_DEL_KEY) begin
            state_d = sts_i.hit ? S_SHINIT : S_RESP;
          end else begin
            if (sts_i.hit) begin
              ctl_o.cap_found = 1'b1;
              ctl_o.set_ok    = 1'b1;
            end
            state_d = S_RESP;
          end
        end
      end
      S_SHINIT: begin
        ctl_o.shift_init = 1'b1;
        ctl_o.dir_down   = (cmd_q == CMD_DEL_KEY);
        state_d          = (cmd_q == CMD_DEL_KEY) ? S_SHDN : S_SHUP;
      end
      S_SHUP: begin
        if (sts_i.busy) begin
          ctl_o.shift_step = 1'b1;
        end else begin
          ctl_o.write_new = 1'b1;
          ctl_o.cnt_inc   = 1'b1;
          ctl_o.set_ok    = 1'b1;
          state_d         = S_RESP;
        end
      end
      S_SHDN: begin
        if (sts_i.busy) begin
          ctl_o.shift_step = 1'b1;
        end else begin
          ctl_o.cnt_dec = 1'b1;
          ctl_o.set_ok  = 1'b1;
          state_d       = S_RESP;
        end
      end
      S_RDW: begin
        ctl_o.cap_found = 1'b1;
        ctl_o.set_ok    = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          ctl_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_INS_END;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
    end
  end

endmodule

>>> rtl/bounded_sequential_record_list_core.sv
// Bounded sequential record list: one item at a time, one result per item.
// Each item passes through the control states; scans and entry moves go one slot per cycle.
// A new item is taken only after the previous result is loaded into the result register,
// which frees the input side.
// Reset clears the entry count and the control state; the record memory is not cleared.
`timescale 1ns / 1ps

module bounded_sequential_record_list_core
  import blsr_pkg::*;
#(
  parameter int CAPACITY = BLSR_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  blsr_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output blsr_out_t out_data_o
);

  blsr_ctl_t ctl;
  blsr_sts_t sts;

  blsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (in_data_i.cmd),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  blsr_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
